// File: design/csfbd_pkg.sv
package csfbd_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FREQ_W = 37;
  localparam int unsigned BAND_W = 8;
  localparam int unsigned POS_W  = 6;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_START = 8'h49;  // 'I'
  localparam logic [BYTE_W-1:0] CHAR_END   = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'

  // Queue geometry shared by both queues
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  // Band table
  localparam int unsigned NUM_BANDS = 10;
  localparam logic [BAND_W-1:0] BAND_NONE = 8'd0;

  typedef logic [FREQ_W-1:0] freq_t;

  localparam freq_t BAND_LOW [NUM_BANDS] = '{
    37'd1800000,  37'd3500000,  37'd7000000,  37'd10100000, 37'd14000000,
    37'd18068000, 37'd21000000, 37'd24890000, 37'd28000000, 37'd50000000
  };
  localparam freq_t BAND_HIGH [NUM_BANDS] = '{
    37'd2000000,  37'd3800000,  37'd7200000,  37'd10150000, 37'd14350000,
    37'd18168000, 37'd21450000, 37'd24990000, 37'd29700000, 37'd52000000
  };
  localparam logic [BAND_W-1:0] BAND_METERS [NUM_BANDS] = '{
    8'd160, 8'd80, 8'd40, 8'd30, 8'd20, 8'd17, 8'd15, 8'd12, 8'd10, 8'd6
  };

  // Closed frame as handed from front to back
  typedef struct packed {
    freq_t freq;
    logic  by_length;
  } frame_rec_t;

  // Finished result
  typedef struct packed {
    freq_t             freq;
    logic [BAND_W-1:0] band;
    logic              by_length;
  } result_t;

  // Look up the band of a frequency; ranges are disjoint and inclusive
  function automatic logic [BAND_W-1:0] band_of(input freq_t f);
    logic [BAND_W-1:0] b;
    b = BAND_NONE;
    for (int k = 0; k < NUM_BANDS; k++) begin
      if (f >= BAND_LOW[k] && f <= BAND_HIGH[k]) begin
        b = BAND_METERS[k];
      end
    end
    return b;
  endfunction

endpackage

// File: design/csfbd_fifo.sv
module csfbd_fifo #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [csfbd_pkg::FIFO_DEPTH];
  logic [csfbd_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [csfbd_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [csfbd_pkg::FIFO_CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  // Status and head
  assign full     = (count_r == csfbd_pkg::FIFO_CNT_W'(csfbd_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= csfbd_pkg::FIFO_CNT_W'(csfbd_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[csfbd_pkg::FIFO_PTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("queue empty after push");

endmodule

// File: design/csfbd_front.sv
module csfbd_front #(
  parameter int unsigned FRAME_MAX_CHARS = 37,
  parameter int unsigned FREQ_FIRST_POS  = 2,
  parameter int unsigned FREQ_DIGITS     = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic [csfbd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                              rec_push,
  output csfbd_pkg::frame_rec_t             rec_data
);

  localparam logic [csfbd_pkg::POS_W-1:0] POS_MAX   =
    csfbd_pkg::POS_W'(FRAME_MAX_CHARS);
  localparam logic [csfbd_pkg::POS_W-1:0] POS_FIRST =
    csfbd_pkg::POS_W'(FREQ_FIRST_POS);
  localparam logic [csfbd_pkg::POS_W-1:0] POS_LAST  =
    csfbd_pkg::POS_W'(FREQ_FIRST_POS + FREQ_DIGITS);

  logic                          in_frame_r, in_frame_nxt;
  logic [csfbd_pkg::POS_W-1:0]   pos_r, pos_nxt;
  csfbd_pkg::freq_t              acc_r, acc_nxt;
  logic                          stop_r, stop_nxt;

  logic [csfbd_pkg::POS_W-1:0]   cur_pos, new_pos;
  csfbd_pkg::freq_t              cur_acc, acc_step;
  logic                          cur_stop;
  logic                          is_start, is_end, is_digit, in_field;
  logic                          store, close_len;
  logic [3:0]                    digit;

  // Classify the byte; the low nibble of '0'..'9' is the digit value
  assign is_start = (rx_byte == csfbd_pkg::CHAR_START);
  assign is_end   = (rx_byte == csfbd_pkg::CHAR_END);
  assign is_digit = (rx_byte >= csfbd_pkg::CHAR_ZERO) && (rx_byte <= csfbd_pkg::CHAR_NINE);
  assign digit    = rx_byte[3:0];

  // A frame start sees a fresh position, accumulator and stop flag
  assign cur_pos  = in_frame_r ? pos_r : '0;
  assign cur_acc  = in_frame_r ? acc_r : '0;
  assign cur_stop = in_frame_r ? stop_r : 1'b0;

  assign store    = take && (in_frame_r ? !is_end : is_start);
  assign in_field = (cur_pos >= POS_FIRST) && (cur_pos < POS_LAST) && !cur_stop;
  assign new_pos  = cur_pos + 1'b1;
  assign close_len = store && (new_pos >= POS_MAX);

  // Multiply by ten as two shifts and an add
  assign acc_step = (cur_acc << 3) + (cur_acc << 1)
                  + csfbd_pkg::freq_t'(digit);

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    stop_nxt     = stop_r;
    rec_push     = 1'b0;
    rec_data     = '{freq: acc_r, by_length: 1'b0};
    if (take && in_frame_r && is_end) begin
      // Close on semicolon
      rec_push     = 1'b1;
      in_frame_nxt = 1'b0;
      pos_nxt      = '0;
    end else if (store) begin
      acc_nxt  = cur_acc;
      stop_nxt = cur_stop;
      if (in_field) begin
        if (is_digit) begin
          acc_nxt = acc_step;
        end else begin
          stop_nxt = 1'b1;
        end
      end
      if (close_len) begin
        // Close on length
        rec_push     = 1'b1;
        rec_data     = '{freq: acc_nxt, by_length: 1'b1};
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
      end else begin
        in_frame_nxt = 1'b1;
        pos_nxt      = new_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      acc_r      <= '0;
      stop_r     <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      stop_r     <= stop_nxt;
    end
  end

  a_close_returns: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |=> (!in_frame_r && pos_r == '0))
    else $error("frame not closed after transaction");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_MAX)
    else $error("position reached frame limit");

  a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (pos_r == '0))
    else $error("position nonzero while hunting");

endmodule

// File: design/csfbd_back.sv
module csfbd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rec_empty,
  input  csfbd_pkg::frame_rec_t         rec_data,
  output logic                          rec_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output csfbd_pkg::result_t            out_data
);

  csfbd_pkg::result_t res;
  logic               res_full;

  // Classify the frequency into a band
  assign res.freq      = rec_data.freq;
  assign res.band      = csfbd_pkg::band_of(rec_data.freq);
  assign res.by_length = rec_data.by_length;

  // Move a record whenever the result queue has room
  assign rec_pop = !rec_empty && !res_full;

  csfbd_fifo #(
    .WIDTH($bits(csfbd_pkg::result_t))
  ) u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_pop),
    .push_data(res),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (out_data),
    .empty    (out_empty)
  );

endmodule

// File: design/cat_status_frequency_band_decoder_top.sv
// Status frame frequency and band decoder.
// Input channel: one received character per transaction on in_rx_byte,
// taken at a clock edge with in_push high and in_full low. Bytes outside a
// frame other than 'I' are dropped; an 'I' opens a frame.
// Result channel: while out_empty is low, the oldest result (frequency in
// hertz, band in metres or 0, and whether the frame closed on length) is on
// the out_ ports; it is taken at an edge with out_pop high.
// Throughput: one character per cycle, sustained, as long as results drain.
// Path of a result: the edge that takes the closing character writes the
// record queue; a later edge, once the result queue has room, moves the
// record through band lookup into the result queue, and out_empty falls.
// Stalls: the parser feeds a two-entry record queue and the band stage a
// two-entry result queue; when the receiver holds off, these fill and
// in_full rises until a result is popped. Bytes never get lost.
// Reset (rst_n low, synchronous): parser returns to hunting, both queues
// empty.
module cat_status_frequency_band_decoder_top #(
  parameter int unsigned FRAME_MAX_CHARS = 37,
  parameter int unsigned FREQ_FIRST_POS  = 2,
  parameter int unsigned FREQ_DIGITS     = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [csfbd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [csfbd_pkg::FREQ_W-1:0]  out_frequency_hz,
  output logic [csfbd_pkg::BAND_W-1:0]  out_band_meters,
  output logic                          out_ended_by_length
);

  logic                  take;
  logic                  rec_push, rec_full, rec_empty, rec_pop;
  csfbd_pkg::frame_rec_t rec_in, rec_out;
  csfbd_pkg::result_t    res;

  // Hold input while the record queue is full
  assign in_full = rec_full;
  assign take    = in_push && !rec_full;

  csfbd_front #(
    .FRAME_MAX_CHARS(FRAME_MAX_CHARS),
    .FREQ_FIRST_POS (FREQ_FIRST_POS),
    .FREQ_DIGITS    (FREQ_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .rec_push(rec_push),
    .rec_data(rec_in)
  );

  csfbd_fifo #(
    .WIDTH($bits(csfbd_pkg::frame_rec_t))
  ) u_rec_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_data(rec_in),
    .full     (rec_full),
    .pop      (rec_pop),
    .pop_data (rec_out),
    .empty    (rec_empty)
  );

  csfbd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_empty(rec_empty),
    .rec_data (rec_out),
    .rec_pop  (rec_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (res)
  );

  assign out_frequency_hz    = res.freq;
  assign out_band_meters     = res.band;
  assign out_ended_by_length = res.by_length;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FRAME_LEN     = 37;
  localparam int unsigned FIELD_FIRST   = 2;
  localparam int unsigned FIELD_DIGITS  = 11;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_BYTES  = 1800;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned NUM_HAM_BANDS = 10;

  localparam logic [csfbd_pkg::BYTE_W-1:0] CHAR_CMD_F = 8'h46;  // 'F'
  localparam logic [csfbd_pkg::BYTE_W-1:0] CHAR_FILL  = 8'h20;  // space

  // Amateur bands, inclusive edges in hertz
  localparam longint unsigned HAM_LO_HZ [NUM_HAM_BANDS] = '{
    64'd1800000,  64'd3500000,  64'd7000000,  64'd10100000, 64'd14000000,
    64'd18068000, 64'd21000000, 64'd24890000, 64'd28000000, 64'd50000000
  };
  localparam longint unsigned HAM_HI_HZ [NUM_HAM_BANDS] = '{
    64'd2000000,  64'd3800000,  64'd7200000,  64'd10150000, 64'd14350000,
    64'd18168000, 64'd21450000, 64'd24990000, 64'd29700000, 64'd52000000
  };
  localparam logic [csfbd_pkg::BAND_W-1:0] HAM_METERS [NUM_HAM_BANDS] = '{
    8'd160, 8'd80, 8'd40, 8'd30, 8'd20, 8'd17, 8'd15, 8'd12, 8'd10, 8'd6
  };

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_push    = 1'b0;
  logic                         in_full;
  logic [csfbd_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic                         out_empty;
  logic                         out_pop    = 1'b0;
  logic [csfbd_pkg::FREQ_W-1:0] out_frequency_hz;
  logic [csfbd_pkg::BAND_W-1:0] out_band_meters;
  logic                         out_ended_by_length;

  // Frame decoder shadow state
  logic                        fr_open;
  logic [csfbd_pkg::POS_W-1:0] fr_pos;
  csfbd_pkg::freq_t            fr_acc;
  logic                        fr_stop;

  csfbd_pkg::result_t pending_reports[$];
  logic [7:0]         frame_bytes[$];

  int          errors      = 0;
  bit          bursty      = 1'b0;
  int unsigned burst_left  = 0;
  bit          in_fire     = 1'b0;
  bit          out_fire    = 1'b0;
  int unsigned idle_cycles = 0;
  logic        pop_hold    = 1'b0;
  logic [15:0] pop_pattern = 16'hFFFF;
  int unsigned pop_tick    = 0;

  cat_status_frequency_band_decoder_top #(
    .FRAME_MAX_CHARS(FRAME_LEN),
    .FREQ_FIRST_POS (FIELD_FIRST),
    .FREQ_DIGITS    (FIELD_DIGITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_rx_byte         (in_rx_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_frequency_hz   (out_frequency_hz),
    .out_band_meters    (out_band_meters),
    .out_ended_by_length(out_ended_by_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [csfbd_pkg::BAND_W-1:0] ham_band(input csfbd_pkg::freq_t hz);
    logic [csfbd_pkg::BAND_W-1:0] m;
    m = csfbd_pkg::BAND_NONE;
    for (int k = 0; k < NUM_HAM_BANDS; k++) begin
      if (hz >= HAM_LO_HZ[k] && hz <= HAM_HI_HZ[k]) begin
        m = HAM_METERS[k];
      end
    end
    return m;
  endfunction

  // Advance the frame decoder by one character; return 1 when a frame closes
  function automatic logic decode_byte(input logic [7:0] c,
                                       output csfbd_pkg::result_t rep);
    logic closes;
    logic by_len;
    closes = 1'b0;
    by_len = 1'b0;
    rep    = '0;
    if (!fr_open) begin
      if (c != csfbd_pkg::CHAR_START) return 1'b0;
      fr_open = 1'b1;
      fr_pos  = '0;
      fr_acc  = '0;
      fr_stop = 1'b0;
    end else if (c == csfbd_pkg::CHAR_END) begin
      closes = 1'b1;
    end
    if (!closes) begin
      // accumulate digits inside the frequency field until a non-digit
      if (fr_pos >= FIELD_FIRST && fr_pos < FIELD_FIRST + FIELD_DIGITS && !fr_stop) begin
        if (c >= csfbd_pkg::CHAR_ZERO && c <= csfbd_pkg::CHAR_NINE) begin
          fr_acc = fr_acc * 10 + (c - csfbd_pkg::CHAR_ZERO);
        end else begin
          fr_stop = 1'b1;
        end
      end
      fr_pos = fr_pos + 1'b1;
      if (fr_pos >= FRAME_LEN || fr_pos == '0) begin
        closes = 1'b1;
        by_len = 1'b1;
      end
    end
    if (closes) begin
      rep.freq      = fr_acc;
      rep.band      = ham_band(fr_acc);
      rep.by_length = by_len;
      fr_open       = 1'b0;
      fr_pos        = '0;
    end
    return closes;
  endfunction

  // Drive one character and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    logic               took;
    csfbd_pkg::result_t rep;
    if (bursty) begin
      if (burst_left == 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_full;
      @(posedge clk);
    end
    if (decode_byte(b, rep)) pending_reports.push_back(rep);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic quiet_input();
    in_push <= 1'b0;
  endtask

  // Hold until every expected report has been popped
  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Append a zero-padded decimal field to the frame under construction
  function automatic void put_decimal(input longint unsigned v, input int n);
    logic [7:0] d[FIELD_DIGITS];
    for (int i = n - 1; i >= 0; i--) begin
      d[i] = csfbd_pkg::CHAR_ZERO + 8'(v % 10);
      v    = v / 10;
    end
    for (int i = 0; i < n; i++) frame_bytes.push_back(d[i]);
  endfunction

  function automatic logic [7:0] rand_digit();
    return csfbd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ((c >= csfbd_pkg::CHAR_ZERO && c <= csfbd_pkg::CHAR_NINE) ||
        c == csfbd_pkg::CHAR_END) c = CHAR_FILL;
    return c;
  endfunction

  // Build and send one mostly well-formed status frame, with optional noise first
  task automatic send_random_frame(output int unsigned sent);
    int unsigned     kind;
    int unsigned     k;
    int unsigned     n;
    int unsigned     tail;
    longint unsigned hz;
    logic [7:0]      c;
    bit              by_semi;
    frame_bytes = {};
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        c = 8'($urandom_range(0, 255));
        send_byte(c == csfbd_pkg::CHAR_START ? CHAR_FILL : c);
      end
    end
    frame_bytes.push_back(csfbd_pkg::CHAR_START);
    frame_bytes.push_back(($urandom_range(0, 7) != 0) ? CHAR_CMD_F : 8'($urandom_range(0, 255)));
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      // in-band, edge or just outside an edge
      k = $urandom_range(0, NUM_HAM_BANDS - 1);
      case ($urandom_range(0, 4))
        0:       hz = HAM_LO_HZ[k];
        1:       hz = HAM_HI_HZ[k];
        2:       hz = HAM_LO_HZ[k] - 1;
        3:       hz = HAM_HI_HZ[k] + 1;
        default: hz = HAM_LO_HZ[k] + $urandom_range(0, 32'(HAM_HI_HZ[k] - HAM_LO_HZ[k]));
      endcase
      put_decimal(hz, FIELD_DIGITS);
    end else if (kind <= 6) begin
      n = $urandom_range(0, FIELD_DIGITS);
      repeat (n) frame_bytes.push_back(rand_digit());
    end else if (kind == 7) begin
      // digits broken by a non-digit
      n = $urandom_range(0, FIELD_DIGITS - 1);
      repeat (n) frame_bytes.push_back(rand_digit());
      frame_bytes.push_back(non_digit());
      repeat ($urandom_range(1, 5)) frame_bytes.push_back(rand_digit());
    end else if (kind == 8) begin
      hz = ($urandom_range(0, 3) == 0) ? 64'd99999999999 :
           {$urandom, $urandom} % 64'd100000000000;
      put_decimal(hz, FIELD_DIGITS);
    end else begin
      repeat ($urandom_range(0, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    by_semi = $urandom_range(0, 3) != 0;
    tail = by_semi ? $urandom_range(0, 8) : FRAME_LEN - frame_bytes.size();
    repeat (tail) begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(8'h20, 8'h7E));
      frame_bytes.push_back(c == csfbd_pkg::CHAR_END ? CHAR_FILL : c);
    end
    if (by_semi) frame_bytes.push_back(csfbd_pkg::CHAR_END);
    sent = frame_bytes.size();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic test_hunting_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(csfbd_pkg::CHAR_END);
    send_byte(csfbd_pkg::CHAR_NINE);
  endtask

  task automatic test_empty_frame();
    send_text("I;");
  endtask

  task automatic test_band_frame();
    send_text("IF7100000;");
  endtask

  task automatic test_field_cases();
    // start char inside a frame, short field, non-digit first, non-digit mid-field
    send_text("II7;");
    send_text("IFA9;");
    send_text("IF1x2;");
  endtask

  task automatic test_length_close();
    send_text("IF99999999999");
    repeat (FRAME_LEN - 13) send_byte(CHAR_FILL);
    // next byte right after a length close must be seen as a frame start
    send_text("I;");
  endtask

  task automatic test_backpressure();
    pop_hold <= 1'b1;
    fork
      begin
        repeat (12) send_text("I;");
        quiet_input();
      end
      begin
        repeat (60) @(posedge clk);
        pop_hold <= 1'b0;
      end
    join
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned total;
    int unsigned got;
    total  = 0;
    bursty = 1'b1;
    while (total < RANDOM_BYTES) begin
      send_random_frame(got);
      total += got;
      if ($urandom_range(0, 15) == 0) bursty = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 60) == 0) begin
        quiet_input();
        wait_drained();
      end
    end
  endtask

  // Receiver: pop on a rotating pattern that is reshuffled now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      pop_tick++;
      if (pop_tick % 48 == 0) begin
        case ($urandom_range(0, 3))
          0:       pop_pattern = '1;
          1:       pop_pattern = 16'($urandom);
          2:       pop_pattern = 16'($urandom | $urandom);
          default: pop_pattern = 16'($urandom & $urandom);
        endcase
      end
      pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      out_pop <= !pop_hold && pop_pattern[0];
    end
  end

  // Sample handshakes mid-cycle and compare each popped report
  always @(negedge clk) begin
    csfbd_pkg::result_t want;
    in_fire  = rst_n && in_push && !in_full;
    out_fire = rst_n && out_pop && !out_empty;
    if (out_fire) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: freq %0d band %0d by_length %0b", $time,
                 out_frequency_hz, out_band_meters, out_ended_by_length);
      end else begin
        want = pending_reports.pop_front();
        if (out_frequency_hz !== want.freq) begin
          errors++;
          $display("%0t: frequency_hz expected %0d actual %0d", $time,
                   want.freq, out_frequency_hz);
        end
        if (out_band_meters !== want.band) begin
          errors++;
          $display("%0t: band_meters expected %0d actual %0d", $time,
                   want.band, out_band_meters);
        end
        if (out_ended_by_length !== want.by_length) begin
          errors++;
          $display("%0t: ended_by_length expected %0b actual %0b", $time,
                   want.by_length, out_ended_by_length);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("cat_status_frequency_band_decoder_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    fr_open = 1'b0;
    fr_pos  = '0;
    fr_acc  = '0;
    fr_stop = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_hunting_noise();
    test_empty_frame();
    test_band_frame();
    test_field_cases();
    test_length_close();
    quiet_input();
    wait_drained();
    test_backpressure();
    test_random_frames();

    quiet_input();
    wait_drained();
    if (pending_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d reports never arrived", $time, pending_reports.size());
    end
    if (errors == 0) begin
      $display("cat_status_frequency_band_decoder_top regression: pass");
    end else begin
      $display("cat_status_frequency_band_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
